// ===== rtl/smi_pkg.sv =====
// Shared constants and helpers for the small matrix inverse block.
// Holds the permutation tables used to walk determinant terms.
// No dependencies.
package smi_pkg;

	// Each permutation packs position n into bits [13-4n -: 2].
	localparam logic [15:0] PERM4 [24] = '{
		16'h0123, 16'h0132, 16'h0213, 16'h0231, 16'h0312, 16'h0321,
		16'h1023, 16'h1032, 16'h1203, 16'h1230, 16'h1302, 16'h1320,
		16'h2013, 16'h2031, 16'h2103, 16'h2130, 16'h2301, 16'h2310,
		16'h3012, 16'h3021, 16'h3102, 16'h3120, 16'h3201, 16'h3210
	};
	localparam logic [23:0] PAR4 = 24'h666666;
	localparam logic [15:0] PERM3 [6] = '{
		16'h0120, 16'h0210, 16'h1020, 16'h1200, 16'h2010, 16'h2100
	};
	localparam logic [5:0] PAR3 = 6'b100110;
	localparam logic [15:0] PERM2 [2] = '{16'h0100, 16'h1000};
	localparam logic [1:0] PAR2 = 2'b10;

	function automatic logic [1:0] perm_at(input logic [2:0] k, input logic [4:0] p,
			input logic [1:0] pos);
		logic [15:0] e;
		logic [1:0] r;
		case (k)
			3'd4: e = PERM4[p];
			3'd3: e = PERM3[p[2:0]];
			3'd2: e = PERM2[p[0]];
			default: e = 16'h0000;
		endcase
		case (pos)
			2'd0: r = e[13:12];
			2'd1: r = e[9:8];
			2'd2: r = e[5:4];
			default: r = e[1:0];
		endcase
		return r;
	endfunction

	function automatic logic perm_odd(input logic [2:0] k, input logic [4:0] p);
		logic r;
		case (k)
			3'd4: r = PAR4[p];
			3'd3: r = PAR3[p[2:0]];
			3'd2: r = PAR2[p[0]];
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Index of the last permutation of k elements.
	function automatic logic [4:0] perm_last(input logic [2:0] k);
		logic [4:0] r;
		case (k)
			3'd4: r = 5'd23;
			3'd3: r = 5'd5;
			3'd2: r = 5'd1;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/smi_addsub.sv =====
// Shared wide adder/subtractor for the small matrix inverse block.
// Serves multiply steps, accumulation, negation and division. No dependencies.
module smi_addsub #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W:0]   y
);
	// y[W] is carry out; on subtract it is set when a >= b
	assign y = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
endmodule

// ===== rtl/small_matrix_inverse_adjugate.sv =====
// DIM x DIM matrix inverse by adjugate, signed fixed point with FRAC_BITS fraction bits.
// Entries are taken one per cycle while busy is low (start high). After the last entry
// busy rises; one wide adder under a sequencer then builds each k x k determinant as
// k! terms of k-1 shift-add products, first for the whole matrix and then for each
// cofactor; each inverse entry adds rounding and a restoring division over NW numerator
// bits, NW = 32*DIM + 2*FRAC_BITS + 8. Uses smi_pkg and smi_addsub. Results appear one
// per strobe on result_valid, row-major, each present for one cycle only: the receiver
// cannot stall. A zero determinant gives DIM*DIM zero results with is_singular set.
module small_matrix_inverse_adjugate #(
	parameter int DIM       = 3,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] entry_value,
	output logic               result_valid,
	output logic signed [31:0] inverse_value,
	output logic               is_singular,
	output logic               saturated,
	output logic               last_entry
);
	import smi_pkg::*;

	localparam int NE    = DIM * DIM;
	localparam int LCW   = $clog2(NE);
	localparam int TW    = 32 * DIM;
	localparam int ACC_W = 32 * DIM + 6;
	localparam int NW    = ACC_W + 2 * FRAC_BITS + 2;
	localparam int UW    = NW + 1;
	localparam int DCW   = $clog2(NW);
	localparam logic [2:0] KDET = 3'(DIM);
	localparam logic [2:0] KCOF = 3'(DIM - 1);
	localparam logic [1:0] DLAST = 2'(DIM - 1);

	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_TFIRST = 4'd1;
	localparam logic [3:0] S_TMUL   = 4'd2;
	localparam logic [3:0] S_TACC   = 4'd3;
	localparam logic [3:0] S_DETCHK = 4'd4;
	localparam logic [3:0] S_ZOUT   = 4'd5;
	localparam logic [3:0] S_CABS   = 4'd6;
	localparam logic [3:0] S_CNUM   = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0]       state_q;
	logic [LCW-1:0]   lc_q;
	logic [31:0]      mat_q [NE];
	logic             cof_q;
	logic [4:0]       perm_q;
	logic [1:0]       pos_q;
	logic [4:0]       bit_q;
	logic [TW-1:0]    term_q;
	logic [TW-1:0]    prod_q;
	logic             tsgn_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] dmag_q;
	logic             dneg_q;
	logic             nneg_q;
	logic [NW-1:0]    num_q;
	logic [ACC_W-1:0] rem_q;
	logic [31:0]      quo_q;
	logic             ovf_q;
	logic [DCW-1:0]   dcnt_q;
	logic [1:0]       oi_q;
	logic [1:0]       oj_q;

	logic             valid_q;
	logic [31:0]      value_q;
	logic             sing_q;
	logic             sat_q;
	logic             last_q;

	logic [2:0]       k_c;
	logic [1:0]       pe_c;
	logic [1:0]       row_c;
	logic [1:0]       col_c;
	logic [LCW-1:0]   addr_c;
	logic [31:0]      raw_c;
	logic [31:0]      mag_c;
	logic [UW-1:0]    ua;
	logic [UW-1:0]    ub;
	logic             usub;
	logic [UW:0]      uy;
	logic [ACC_W:0]   rem_sh;
	logic             qnz_c;
	logic             qneg_c;
	logic [31:0]      limit_c;
	logic             sat_c;
	logic [31:0]      val_c;
	logic             olast_c;

	assign k_c  = cof_q ? KCOF : KDET;
	assign pe_c = perm_at(k_c, perm_q, pos_q);

	// Cofactor (j,i) drops row j and column i of the stored matrix.
	always_comb begin
		if (cof_q) begin
			row_c = (pos_q < oj_q) ? pos_q : pos_q + 2'd1;
			col_c = (pe_c < oi_q) ? pe_c : pe_c + 2'd1;
		end else begin
			row_c = pos_q;
			col_c = pe_c;
		end
	end

	assign addr_c = LCW'(int'(row_c) * DIM + int'(col_c));
	assign raw_c  = mat_q[addr_c];
	assign mag_c  = raw_c[31] ? (~raw_c + 32'd1) : raw_c;
	assign rem_sh = {rem_q, num_q[NW-1]};

	always_comb begin
		ua   = '0;
		ub   = '0;
		usub = 1'b0;
		case (state_q)
			S_TMUL: begin
				ua = UW'({prod_q, 1'b0});
				ub = mag_c[bit_q] ? UW'(term_q) : '0;
			end
			S_TACC: begin
				ua   = UW'(acc_q);
				ub   = UW'(term_q);
				usub = tsgn_q;
			end
			S_DETCHK, S_CABS: begin
				ub   = UW'(acc_q);
				usub = 1'b1;
			end
			S_CNUM: begin
				ua = UW'({acc_q, {(2 * FRAC_BITS + 1){1'b0}}});
				ub = UW'(dmag_q);
			end
			S_DIV: begin
				ua   = UW'(rem_sh);
				ub   = UW'({dmag_q, 1'b0});
				usub = 1'b1;
			end
			default: begin
				ua = '0;
			end
		endcase
	end

	smi_addsub #(.W(UW)) u_alu (
		.a   (ua),
		.b   (ub),
		.sub (usub),
		.y   (uy)
	);

	assign qnz_c   = ovf_q || (quo_q != 32'd0);
	assign qneg_c  = (nneg_q != dneg_q) && qnz_c;
	assign limit_c = qneg_c ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign sat_c   = ovf_q || (quo_q > limit_c);
	assign val_c   = qneg_c ? (32'd0 - (sat_c ? limit_c : quo_q)) : (sat_c ? limit_c : quo_q);
	assign olast_c = (oi_q == DLAST) && (oj_q == DLAST);

	// Matrix store: written during load only.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && start) begin
			mat_q[lc_q] <= entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			lc_q    <= '0;
			cof_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (start) begin
						if (lc_q == LCW'(NE - 1)) begin
							lc_q    <= '0;
							cof_q   <= 1'b0;
							state_q <= S_TFIRST;
						end else begin
							lc_q <= lc_q + 1'b1;
						end
					end
				end
				S_TFIRST: begin
					state_q <= (k_c == 3'd1) ? S_TACC : S_TMUL;
				end
				S_TMUL: begin
					if (bit_q == 5'd0 && pos_q == 2'(k_c - 3'd1)) begin
						state_q <= S_TACC;
					end
				end
				S_TACC: begin
					if (perm_q == perm_last(k_c)) begin
						state_q <= cof_q ? S_CABS : S_DETCHK;
					end else begin
						state_q <= S_TFIRST;
					end
				end
				S_DETCHK: begin
					if (acc_q == '0) begin
						state_q <= S_ZOUT;
					end else begin
						cof_q   <= 1'b1;
						state_q <= S_TFIRST;
					end
				end
				S_ZOUT: begin
					valid_q <= 1'b1;
					if (olast_c) begin
						state_q <= S_LOAD;
					end
				end
				S_CABS: state_q <= S_CNUM;
				S_CNUM: state_q <= S_DIV;
				S_DIV: begin
					if (dcnt_q == '0) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					valid_q <= 1'b1;
					state_q <= olast_c ? S_LOAD : S_TFIRST;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				perm_q <= '0;
				pos_q  <= '0;
				acc_q  <= '0;
			end
			S_TFIRST: begin
				term_q <= TW'(mag_c);
				tsgn_q <= raw_c[31] ^ perm_odd(k_c, perm_q);
				prod_q <= '0;
				bit_q  <= 5'd31;
				pos_q  <= 2'd1;
			end
			S_TMUL: begin
				if (bit_q == 5'd0) begin
					term_q <= uy[TW-1:0];
					tsgn_q <= tsgn_q ^ raw_c[31];
					prod_q <= '0;
					bit_q  <= 5'd31;
					pos_q  <= pos_q + 2'd1;
				end else begin
					prod_q <= uy[TW-1:0];
					bit_q  <= bit_q - 5'd1;
				end
			end
			S_TACC: begin
				acc_q  <= uy[ACC_W-1:0];
				perm_q <= perm_q + 5'd1;
				pos_q  <= '0;
			end
			S_DETCHK: begin
				dneg_q <= acc_q[ACC_W-1];
				dmag_q <= acc_q[ACC_W-1] ? uy[ACC_W-1:0] : acc_q;
				oi_q   <= '0;
				oj_q   <= '0;
				perm_q <= '0;
				pos_q  <= '0;
				acc_q  <= '0;
			end
			S_ZOUT: begin
				value_q <= '0;
				sing_q  <= 1'b1;
				sat_q   <= 1'b0;
				last_q  <= olast_c;
				if (oj_q == DLAST) begin
					oj_q <= '0;
					oi_q <= oi_q + 2'd1;
				end else begin
					oj_q <= oj_q + 2'd1;
				end
			end
			S_CABS: begin
				nneg_q <= acc_q[ACC_W-1] ^ oi_q[0] ^ oj_q[0];
				acc_q  <= acc_q[ACC_W-1] ? uy[ACC_W-1:0] : acc_q;
			end
			S_CNUM: begin
				// round half away: (2|N| + |D|) / (2|D|)
				num_q  <= uy[NW-1:0];
				rem_q  <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
				dcnt_q <= DCW'(NW - 1);
			end
			S_DIV: begin
				num_q  <= {num_q[NW-2:0], 1'b0};
				quo_q  <= {quo_q[30:0], uy[UW]};
				ovf_q  <= ovf_q | quo_q[31];
				rem_q  <= uy[UW] ? uy[ACC_W-1:0] : rem_sh[ACC_W-1:0];
				dcnt_q <= dcnt_q - 1'b1;
			end
			S_OUT: begin
				value_q <= val_c;
				sing_q  <= 1'b0;
				sat_q   <= sat_c;
				last_q  <= olast_c;
				perm_q  <= '0;
				pos_q   <= '0;
				acc_q   <= '0;
				if (oj_q == DLAST) begin
					oj_q <= '0;
					oi_q <= oi_q + 2'd1;
				end else begin
					oj_q <= oj_q + 2'd1;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign busy          = (state_q != S_LOAD);
	assign result_valid  = valid_q;
	assign inverse_value = value_q;
	assign is_singular   = sing_q;
	assign saturated     = sat_q;
	assign last_entry    = last_q;

`ifndef SYNTH
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_singular |-> inverse_value == 32'sd0 && !saturated)
		else $error("singular result carries a value");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_entry |-> !busy)
		else $error("still busy after final result");
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a transfer");
	a_no_strobe_load: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !result_valid)
		else $error("result strobe while loading");
`endif

endmodule
